/* hw/rtl/wrmse_pkg.sv */
// Package for the weighted RMSE accumulator: widths, codes and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wrmse_pkg;

    // Sample and field widths.
    localparam int SAMPLE_WIDTH = 20;
    localparam int MAG_WIDTH    = SAMPLE_WIDTH;
    localparam int SQ_WIDTH     = 2 * MAG_WIDTH;
    localparam int WEIGHT_WIDTH = 16;
    localparam int TERM_WIDTH   = SQ_WIDTH + WEIGHT_WIDTH;
    localparam int SUM_WIDTH    = 64;
    localparam int WSUM_WIDTH   = 32;
    localparam int RMSE_WIDTH   = 20;
    localparam int ROOT_WIDTH   = SUM_WIDTH / 2;
    localparam int SREM_WIDTH   = ROOT_WIDTH + 2;
    localparam int STATUS_WIDTH = 2;

    // A weight of 1.0 in Q4.12.
    localparam logic [WEIGHT_WIDTH-1:0] UNIT_WEIGHT = WEIGHT_WIDTH'(4096);

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Step counter of the back end: one count per quotient bit or root bit.
    localparam int CNT_WIDTH = $clog2(SUM_WIDTH);

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_SAT   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_DONE
    } back_state_t;

    // One finished set, handed from the front to the back end.
    typedef struct packed {
        logic [SUM_WIDTH-1:0]  squared_sum;
        logic [WSUM_WIDTH-1:0] weight_sum;
        logic                  saturated;
    } job_t;

endpackage

/* hw/rtl/wrmse_front.sv */
// Front part: takes sample requests, squares and weights the error, and
// keeps the saturating sums. Depends on wrmse_pkg.
`timescale 1ns / 1ps

module wrmse_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                weighted_mode,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [wrmse_pkg::SAMPLE_WIDTH-1:0] s_actual_value,
    input  logic signed [wrmse_pkg::SAMPLE_WIDTH-1:0] s_predicted_value,
    input  logic [wrmse_pkg::WEIGHT_WIDTH-1:0]  s_weight,
    input  logic                                s_last,
    output logic                                job_push,
    output wrmse_pkg::job_t                     job_data,
    input  logic                                job_full
);
    import wrmse_pkg::*;

    logic signed [SAMPLE_WIDTH:0]  diff;
    logic [SAMPLE_WIDTH:0]         diff_abs;
    logic                          advance;

    logic                          v1_reg, v2_reg, v3_reg;
    logic                          last1_reg, last2_reg, last3_reg;
    logic [MAG_WIDTH-1:0]          mag1_reg;
    logic [WEIGHT_WIDTH-1:0]       w1_reg, w2_reg, w3_reg;
    logic [SQ_WIDTH-1:0]           sq2_reg;
    logic [TERM_WIDTH-1:0]         term3_reg;

    logic [SUM_WIDTH-1:0]          sum_reg, sum_next;
    logic [WSUM_WIDTH-1:0]         wsum_reg, wsum_next;
    logic                          sat_reg, sat_next;
    logic [SUM_WIDTH:0]            sum_add;
    logic [WSUM_WIDTH:0]           wsum_add;
    logic [SUM_WIDTH-1:0]          sum_upd;
    logic [WSUM_WIDTH-1:0]         wsum_upd;
    logic                          sat_upd;

    // The whole pipe holds only when a finished set finds the queue full.
    assign advance = !(v3_reg && last3_reg && job_full);
    assign s_ready = advance;

    // Magnitude of the error, from sign-extended samples.
    assign diff     = {s_actual_value[SAMPLE_WIDTH-1], s_actual_value}
                    - {s_predicted_value[SAMPLE_WIDTH-1], s_predicted_value};
    assign diff_abs = diff[SAMPLE_WIDTH] ? (SAMPLE_WIDTH+1)'(-diff) : diff;

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one captures the request, stage two squares, stage three weights.
    always_ff @(posedge aclk) begin
        if (advance) begin
            mag1_reg  <= diff_abs[MAG_WIDTH-1:0];
            w1_reg    <= weighted_mode ? s_weight : UNIT_WEIGHT;
            last1_reg <= s_last;
            sq2_reg   <= SQ_WIDTH'(mag1_reg * mag1_reg);
            w2_reg    <= w1_reg;
            last2_reg <= last1_reg;
            term3_reg <= TERM_WIDTH'(sq2_reg * w2_reg);
            w3_reg    <= w2_reg;
            last3_reg <= last2_reg;
        end
    end

    // Saturating additions into both sums.
    always_comb begin
        sum_add  = {1'b0, sum_reg} + {{(SUM_WIDTH + 1 - TERM_WIDTH){1'b0}}, term3_reg};
        wsum_add = {1'b0, wsum_reg} + {{(WSUM_WIDTH + 1 - WEIGHT_WIDTH){1'b0}}, w3_reg};
        sum_upd  = sum_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_add[SUM_WIDTH-1:0];
        wsum_upd = wsum_add[WSUM_WIDTH] ? {WSUM_WIDTH{1'b1}} : wsum_add[WSUM_WIDTH-1:0];
        sat_upd  = sat_reg | sum_add[SUM_WIDTH] | wsum_add[WSUM_WIDTH];
    end

    // Hand a finished set to the queue and start the next one from zero.
    always_comb begin
        sum_next  = sum_reg;
        wsum_next = wsum_reg;
        sat_next  = sat_reg;
        job_push  = 1'b0;
        job_data.squared_sum = sum_upd;
        job_data.weight_sum  = wsum_upd;
        job_data.saturated   = sat_upd;
        if (v3_reg && advance) begin
            if (last3_reg) begin
                job_push  = 1'b1;
                sum_next  = '0;
                wsum_next = '0;
                sat_next  = 1'b0;
            end else begin
                sum_next  = sum_upd;
                wsum_next = wsum_upd;
                sat_next  = sat_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            wsum_reg <= '0;
            sat_reg  <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            wsum_reg <= wsum_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

/* hw/rtl/wrmse_queue.sv */
// Short queue of finished sets between the front and back parts.
// Depends on wrmse_pkg.
`timescale 1ns / 1ps

module wrmse_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wrmse_pkg::job_t push_data,
    output logic            full,
    input  logic            pop,
    output wrmse_pkg::job_t pop_data,
    output logic            empty
);
    import wrmse_pkg::*;

    job_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign full     = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/wrmse_back.sv */
// Back part: divides the weighted sum by the weight sum one bit a cycle,
// takes the integer square root two bits a cycle, and holds the result
// request. Depends on wrmse_pkg.
`timescale 1ns / 1ps

module wrmse_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_empty,
    input  wrmse_pkg::job_t                   job_data,
    output logic                              job_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [wrmse_pkg::RMSE_WIDTH-1:0]  m_rmse,
    output logic [wrmse_pkg::STATUS_WIDTH-1:0] m_status
);
    import wrmse_pkg::*;

    back_state_t             state_reg, state_next;
    logic [CNT_WIDTH-1:0]    cnt_reg;
    logic [SUM_WIDTH-1:0]    quo_reg;
    logic [WSUM_WIDTH-1:0]   rem_reg;
    logic [WSUM_WIDTH-1:0]   den_reg;
    logic [SUM_WIDTH-1:0]    rad_reg;
    logic [SREM_WIDTH-1:0]   srem_reg;
    logic [ROOT_WIDTH-1:0]   root_reg;
    logic [RMSE_WIDTH-1:0]   res_rmse_reg;
    status_t                 res_status_reg;
    logic                    m_valid_reg;
    logic [RMSE_WIDTH-1:0]   m_rmse_reg;
    status_t                 m_status_reg;

    logic                    out_free;
    logic                    load_out;
    logic                    div_last, sqrt_last;
    logic [WSUM_WIDTH:0]     div_trial;
    logic                    div_bit;
    logic [WSUM_WIDTH-1:0]   rem_next;
    logic [SUM_WIDTH-1:0]    quo_next;
    logic [SREM_WIDTH+1:0]   sqrt_trial_rem;
    logic [SREM_WIDTH+1:0]   sqrt_trial;
    logic                    sqrt_bit;
    logic [SREM_WIDTH-1:0]   srem_next;
    logic [ROOT_WIDTH-1:0]   root_next;
    logic [RMSE_WIDTH-1:0]   root_clamped;

    assign out_free  = !m_valid_reg || m_ready;
    assign div_last  = (cnt_reg == CNT_WIDTH'(SUM_WIDTH - 1));
    assign sqrt_last = (cnt_reg == CNT_WIDTH'(ROOT_WIDTH - 1));

    // One restoring division step.
    always_comb begin
        div_trial = {rem_reg, quo_reg[SUM_WIDTH-1]};
        div_bit   = (div_trial >= {1'b0, den_reg});
        rem_next  = div_bit ? WSUM_WIDTH'(div_trial - {1'b0, den_reg})
                            : div_trial[WSUM_WIDTH-1:0];
        quo_next  = {quo_reg[SUM_WIDTH-2:0], div_bit};
    end

    // One square root step, consuming the top two bits of the radicand.
    always_comb begin
        sqrt_trial_rem = {srem_reg, rad_reg[SUM_WIDTH-1 -: 2]};
        sqrt_trial     = {2'b00, root_reg, 2'b01};
        sqrt_bit       = (sqrt_trial_rem >= sqrt_trial);
        srem_next      = sqrt_bit ? SREM_WIDTH'(sqrt_trial_rem - sqrt_trial)
                                  : sqrt_trial_rem[SREM_WIDTH-1:0];
        root_next      = {root_reg[ROOT_WIDTH-2:0], sqrt_bit};
        root_clamped   = (root_next[ROOT_WIDTH-1:RMSE_WIDTH] != '0) ? {RMSE_WIDTH{1'b1}}
                       : root_next[RMSE_WIDTH-1:0];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!job_empty) begin
                    if (job_data.weight_sum == '0 || job_data.saturated) begin
                        state_next = BK_DONE;
                    end else begin
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV: begin
                if (div_last) begin
                    state_next = BK_SQRT;
                end
            end
            BK_SQRT: begin
                if (sqrt_last) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        job_pop  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE: job_pop  = !job_empty;
            BK_DIV:  job_pop  = 1'b0;
            BK_SQRT: job_pop  = 1'b0;
            BK_DONE: load_out = out_free;
            default: begin
                job_pop  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath of the divider and square root.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            BK_IDLE: begin
                quo_reg  <= job_data.squared_sum;
                rem_reg  <= '0;
                den_reg  <= job_data.weight_sum;
                cnt_reg  <= '0;
                res_rmse_reg <= '0;
                if (job_data.weight_sum == '0) begin
                    res_status_reg <= STATUS_EMPTY;
                end else if (job_data.saturated) begin
                    res_status_reg <= STATUS_SAT;
                end else begin
                    res_status_reg <= STATUS_OK;
                end
            end
            BK_DIV: begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                cnt_reg  <= div_last ? '0 : cnt_reg + 1'b1;
                rad_reg  <= quo_next;
                srem_reg <= '0;
                root_reg <= '0;
            end
            BK_SQRT: begin
                rad_reg  <= {rad_reg[SUM_WIDTH-3:0], 2'b00};
                srem_reg <= srem_next;
                root_reg <= root_next;
                cnt_reg  <= cnt_reg + 1'b1;
                res_rmse_reg <= root_clamped;
            end
            BK_DONE: begin
                cnt_reg <= '0;
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    // Result request register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_rmse_reg   <= res_rmse_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_rmse   = m_rmse_reg;
    assign m_status = m_status_reg;

endmodule

/* hw/rtl/weighted_rmse_accumulator_unit.sv */
// Top level of the weighted RMSE accumulator: mode register, front part,
// queue of finished sets and back part. Depends on wrmse_pkg and submodules.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_valid/s_ready    actual, predicted, weight, last
// m_*       out        m_valid/m_ready    rmse, status
// cfg_*     in         cfg_we             cfg_wdata (weighted mode)
//
// One sample request a cycle enters a three-stage multiply pipe while s_ready
// is high; the sums are registered after the third stage. The back part loads
// a set, runs the bit-serial division, then the two-bit-a-cycle root, and
// hands the result off; an empty or saturated set goes straight from load to
// hand-off. Sets queue two deep; the front stalls only when a last item finds
// it full. Reset is synchronous and active low and clears all control state.
`timescale 1ns / 1ps

module weighted_rmse_accumulator_unit (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_we,
    input  logic                                     cfg_wdata,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [wrmse_pkg::SAMPLE_WIDTH-1:0] s_actual_value,
    input  logic signed [wrmse_pkg::SAMPLE_WIDTH-1:0] s_predicted_value,
    input  logic [wrmse_pkg::WEIGHT_WIDTH-1:0]       s_weight,
    input  logic                                     s_last,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [wrmse_pkg::RMSE_WIDTH-1:0]         m_rmse,
    output logic [wrmse_pkg::STATUS_WIDTH-1:0]       m_status
);
    import wrmse_pkg::*;

    logic weighted_mode_reg;
    logic job_push, job_full, job_pop, job_empty;
    job_t push_data, pop_data;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weighted_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            weighted_mode_reg <= cfg_wdata;
        end
    end

    // Accumulating front part.
    wrmse_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .weighted_mode     (weighted_mode_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_actual_value    (s_actual_value),
        .s_predicted_value (s_predicted_value),
        .s_weight          (s_weight),
        .s_last            (s_last),
        .job_push          (job_push),
        .job_data          (push_data),
        .job_full          (job_full)
    );

    // Queue of finished sets.
    wrmse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (push_data),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (pop_data),
        .empty     (job_empty)
    );

    // Divide and square root back part.
    wrmse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_empty (job_empty),
        .job_data  (pop_data),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rmse    (m_rmse),
        .m_status  (m_status)
    );

endmodule
